// ----- hdl/fcba_pkg.sv -----
// Shared types and constants for the chained block allocator.
// No dependencies.
package fcba_pkg;

  localparam int BLOCKS = 1024;
  localparam int AW     = $clog2(BLOCKS);
  localparam int CW     = $clog2(BLOCKS + 1);

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NOSPACE = 2'd1,
    STAT_RANGE   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    KIND_FREE = 2'd0,
    KIND_END  = 2'd1,
    KIND_NEXT = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t         kind;
    logic [AW-1:0] nxt;
  } link_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    link_t         wdata;
    logic [AW-1:0] raddr;
  } ram_req_t;

  typedef enum logic [2:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_ALLOC,
    FSM_ALLOC_END,
    FSM_FREE,
    FSM_READ
  } fsm_t;

endpackage

// ----- hdl/fat_chain_block_allocator_unit.sv -----
// Top level of the chained block allocator: sequencer and datapath around the link table.
// Depends on fcba_pkg and fcba_link_ram.
//
// Usage: a request is taken on a rising edge with start high and busy low.
// command selects allocate, free run, read link or clear; block and count
// give the operands. Exactly one result follows per request: done is high
// for one cycle with status, head_block, link_kind, next_block and
// free_blocks valid in that cycle. The receiver cannot stall; it must take
// the result in that cycle.
// The link table has one read port and one write port; allocate and free
// scan it one entry per cycle:
//   allocate: the scan stops at the last block taken; a zero or oversized
//             request is answered from idle with no scan
//   free run: the run length is clipped to the end of the table; a zero
//             length or bad start is answered from idle with no scan
//   read link: a single table read
//   clear: one table entry written per cycle
// One request is in flight at a time; busy stays high until its result.
// After reset busy is high while the table is swept free; that sweep gives no result.
module fat_chain_block_allocator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [9:0]  block,
  input  logic [10:0] count,
  output logic        done,
  output logic [1:0]  status,
  output logic [9:0]  head_block,
  output logic [1:0]  link_kind,
  output logic [9:0]  next_block,
  output logic [10:0] free_blocks
);
  import fcba_pkg::*;

  fsm_t          state, state_next;
  ram_req_t      req;
  link_t         rdata;

  logic [AW-1:0] addr;
  logic [AW-1:0] chk_addr;
  logic          chk_vld;
  logic [CW-1:0] need;
  logic [AW-1:0] prev;
  logic          have_prev;
  logic [AW-1:0] head;
  logic [CW-1:0] freecnt;
  logic          clr_rsp;

  logic          accept;
  cmd_t          cmd;
  logic          blk_oor;
  logic          alloc_bad;
  logic [CW-1:0] room;
  logic [CW-1:0] run_len;
  logic          alloc_hit;
  logic          free_hit;

  fcba_link_ram u_ram (
    .clk  (clk),
    .req  (req),
    .rdata(rdata)
  );

  assign accept    = start && !busy;
  assign cmd       = cmd_t'(command);
  assign blk_oor   = CW'(block) >= CW'(BLOCKS);
  assign alloc_bad = (count == '0) || (count > freecnt);
  assign room      = CW'(BLOCKS) - CW'(block);
  assign run_len   = (count < room) ? count : room;
  assign alloc_hit = chk_vld && (rdata.kind == KIND_FREE);
  assign free_hit  = chk_vld && (rdata.kind != KIND_FREE);
  assign busy        = (state != FSM_IDLE);
  assign free_blocks = freecnt;

  always_comb begin
    state_next = state;
    unique case (state)
      FSM_CLEAR: begin
        if (addr == AW'(BLOCKS - 1)) state_next = FSM_IDLE;
      end
      FSM_IDLE: begin
        if (accept) begin
          unique case (cmd)
            CMD_ALLOC: if (!alloc_bad) state_next = FSM_ALLOC;
            CMD_FREE:  if (!blk_oor && count != '0) state_next = FSM_FREE;
            CMD_READ:  if (!blk_oor) state_next = FSM_READ;
            CMD_CLEAR: state_next = FSM_CLEAR;
            default:   state_next = FSM_IDLE;
          endcase
        end
      end
      FSM_ALLOC: begin
        if (alloc_hit && need == CW'(1)) state_next = FSM_ALLOC_END;
      end
      FSM_ALLOC_END: state_next = FSM_IDLE;
      FSM_FREE: begin
        if (need == '0 && !chk_vld) state_next = FSM_IDLE;
      end
      FSM_READ: state_next = FSM_IDLE;
      default: state_next = FSM_IDLE;
    endcase
  end

  always_comb begin
    req.we    = 1'b0;
    req.waddr = addr;
    req.wdata = '{kind: KIND_FREE, nxt: '0};
    req.raddr = addr;
    unique case (state)
      FSM_CLEAR: begin
        req.we = 1'b1;
      end
      FSM_IDLE: begin
        req.raddr = AW'(block);
      end
      FSM_ALLOC: begin
        req.we    = alloc_hit && have_prev;
        req.waddr = prev;
        req.wdata = '{kind: KIND_NEXT, nxt: chk_addr};
      end
      FSM_ALLOC_END: begin
        req.we    = 1'b1;
        req.waddr = prev;
        req.wdata = '{kind: KIND_END, nxt: '0};
      end
      FSM_FREE: begin
        req.we    = free_hit;
        req.waddr = chk_addr;
      end
      FSM_READ: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= FSM_CLEAR;
      addr    <= '0;
      freecnt <= CW'(BLOCKS);
      clr_rsp <= 1'b0;
      chk_vld <= 1'b0;
      done    <= 1'b0;
    end else begin
      state      <= state_next;
      done       <= 1'b0;
      status     <= STAT_OK;
      head_block <= '0;
      link_kind  <= KIND_FREE;
      next_block <= '0;
      unique case (state)
        FSM_CLEAR: begin
          addr <= addr + AW'(1);
          if (addr == AW'(BLOCKS - 1)) begin
            done <= clr_rsp;
          end
        end
        FSM_IDLE: begin
          if (accept) begin
            chk_vld   <= 1'b0;
            have_prev <= 1'b0;
            unique case (cmd)
              CMD_ALLOC: begin
                need <= count;
                addr <= '0;
                if (alloc_bad) begin
                  done   <= 1'b1;
                  status <= STAT_NOSPACE;
                end
              end
              CMD_FREE: begin
                need <= run_len;
                addr <= AW'(block);
                if (blk_oor) begin
                  done   <= 1'b1;
                  status <= STAT_RANGE;
                end else if (count == '0) begin
                  done <= 1'b1;
                end
              end
              CMD_READ: begin
                if (blk_oor) begin
                  done   <= 1'b1;
                  status <= STAT_RANGE;
                end
              end
              CMD_CLEAR: begin
                addr    <= '0;
                clr_rsp <= 1'b1;
                freecnt <= CW'(BLOCKS);
              end
              default: ;
            endcase
          end
        end
        FSM_ALLOC: begin
          chk_addr <= addr;
          chk_vld  <= 1'b1;
          addr     <= addr + AW'(1);
          if (alloc_hit) begin
            if (!have_prev) head <= chk_addr;
            prev      <= chk_addr;
            have_prev <= 1'b1;
            need      <= need - CW'(1);
            freecnt   <= freecnt - CW'(1);
          end
        end
        FSM_ALLOC_END: begin
          done       <= 1'b1;
          head_block <= head;
        end
        FSM_FREE: begin
          chk_addr <= addr;
          chk_vld  <= (need != '0);
          if (need != '0) begin
            addr <= addr + AW'(1);
            need <= need - CW'(1);
          end
          if (free_hit) freecnt <= freecnt + CW'(1);
          if (need == '0 && !chk_vld) done <= 1'b1;
        end
        FSM_READ: begin
          done      <= 1'b1;
          link_kind <= rdata.kind;
          if (rdata.kind == KIND_NEXT) next_block <= rdata.nxt;
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- hdl/fcba_link_ram.sv -----
// Link table memory: one write port, one read port, registered read data.
// Depends on fcba_pkg.
module fcba_link_ram (
  input  logic              clk,
  input  fcba_pkg::ram_req_t req,
  output fcba_pkg::link_t   rdata
);
  import fcba_pkg::*;

  link_t mem [BLOCKS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule
